@@ hdl/owb_pkg.sv @@
// owb_pkg: shared types, command codes, register indexes and reset values
// for the 1-Wire bus master. No dependencies.
package owb_pkg;

    localparam int COUNT_WIDTH_DEF = 10;
    localparam int BITS_PER_BYTE   = 8;
    localparam int BIT_IDX_W       = $clog2(BITS_PER_BYTE);

    // timing registers
    localparam int REG_W     = 10;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int APB_AW    = REG_IDX_W + 2;
    localparam int APB_DW    = 32;

    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_RECOVER = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_LOW     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

    localparam logic [REG_W-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [REG_W-1:0] RST_PRESENCE_WAIT = 10'd70;
    localparam logic [REG_W-1:0] RST_RESET_RECOVER = 10'd500;
    localparam logic [REG_W-1:0] RST_WRITE_LOW     = 10'd10;
    localparam logic [REG_W-1:0] RST_WRITE_HOLD    = 10'd50;
    localparam logic [REG_W-1:0] RST_READ_LOW      = 10'd4;
    localparam logic [REG_W-1:0] RST_READ_SAMPLE   = 10'd6;
    localparam logic [REG_W-1:0] RST_READ_TAIL     = 10'd50;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

    // command codes
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic                     drive_low;
        logic                     busy_res;
        logic                     done_res;
        logic                     presence;
        logic [BITS_PER_BYTE-1:0] read_data;
        logic                     rejected;
    } result_t;

endpackage

@@ hdl/owb_regs.sv @@
// owb_regs: APB register bank holding the eight slot timing registers.
// Depends on owb_pkg.
module owb_regs #(
    parameter int COUNT_WIDTH = owb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [owb_pkg::APB_AW-1:0] paddr,
    input  logic [owb_pkg::APB_DW-1:0] pwdata,
    output logic [owb_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output owb_pkg::cfg_regs_t         cfg
);
    import owb_pkg::*;

    // written values are clipped to the counter width
    localparam logic [REG_W-1:0] WR_MASK =
        (COUNT_WIDTH >= REG_W) ? {REG_W{1'b1}} : REG_W'((1 << COUNT_WIDTH) - 1);

    cfg_regs_t             regs_reg;
    logic [REG_IDX_W-1:0]  idx;
    logic                  wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = APB_DW'(regs_reg[idx]);
    assign cfg    = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_RESET_LOW]     <= RST_RESET_LOW;
            regs_reg[REG_PRESENCE_WAIT] <= RST_PRESENCE_WAIT;
            regs_reg[REG_RESET_RECOVER] <= RST_RESET_RECOVER;
            regs_reg[REG_WRITE_LOW]     <= RST_WRITE_LOW;
            regs_reg[REG_WRITE_HOLD]    <= RST_WRITE_HOLD;
            regs_reg[REG_READ_LOW]      <= RST_READ_LOW;
            regs_reg[REG_READ_SAMPLE]   <= RST_READ_SAMPLE;
            regs_reg[REG_READ_TAIL]     <= RST_READ_TAIL;
        end
        else if (wr_en && pready)
        begin
            regs_reg[idx] <= pwdata[REG_W-1:0] & WR_MASK;
        end
    end

endmodule

@@ hdl/owb_seq.sv @@
// owb_seq: 1-Wire slot sequencer. One tick per accepted beat; updates the
// phase state and produces that tick's result. Depends on owb_pkg.
module owb_seq #(
    parameter int COUNT_WIDTH = owb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [owb_pkg::OP_W-1:0]          op,
    input  logic [owb_pkg::BITS_PER_BYTE-1:0] data_byte,
    input  logic                              line_level,
    input  owb_pkg::cfg_regs_t                cfg,
    output owb_pkg::result_t                  res
);
    import owb_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_RST_LOW     = 4'd1,
        PH_RST_WAIT    = 4'd2,
        PH_RST_RECOVER = 4'd3,
        PH_WR_LOW      = 4'd4,
        PH_WR_HOLD     = 4'd5,
        PH_RD_LOW      = 4'd6,
        PH_RD_WAIT     = 4'd7,
        PH_RD_TAIL     = 4'd8
    } phase_t;

    phase_t                   phase_reg,    phase_next;
    logic [COUNT_WIDTH-1:0]   tick_reg,     tick_next;
    logic [BIT_IDX_W-1:0]     bit_idx_reg,  bit_idx_next;
    logic [BITS_PER_BYTE-1:0] shift_reg,    shift_next;
    logic [OP_W-1:0]          kind_reg,     kind_next;
    logic                     pres_reg,     pres_next;

    logic [COUNT_WIDTH-1:0]   tick_inc;
    logic [REG_W-1:0]         len;
    logic                     last_bit;
    logic                     phase_end;

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        kind_next    = kind_reg;
        pres_next    = pres_reg;
        res          = '0;
        len          = REG_W'(1);
        tick_inc     = '0;
        last_bit     = 1'b0;
        phase_end    = 1'b0;

        // command start on an idle tick; that tick is already the first of the phase
        if (phase_reg == PH_IDLE)
        begin
            if (op != OP_NONE)
            begin
                kind_next    = op;
                tick_next    = '0;
                bit_idx_next = '0;
                shift_next   = (op == OP_WRITE) ? data_byte : '0;
                case (op)
                    OP_RESET: phase_next = PH_RST_LOW;
                    OP_WRITE: phase_next = PH_WR_LOW;
                    default:  phase_next = PH_RD_LOW;
                endcase
            end
        end
        else if (op != OP_NONE)
        begin
            res.rejected = 1'b1;
        end

        if (phase_next != PH_IDLE)
        begin
            last_bit = (bit_idx_next == BIT_IDX_W'(BITS_PER_BYTE - 1));

            case (phase_next)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res.drive_low = 1'b1;
                PH_WR_HOLD: res.drive_low = ~shift_next[bit_idx_next];
                default:    res.drive_low = 1'b0;
            endcase

            case (phase_next)
                PH_RST_LOW:     len = cfg[REG_RESET_LOW];
                PH_RST_WAIT:    len = cfg[REG_PRESENCE_WAIT];
                PH_RST_RECOVER: len = cfg[REG_RESET_RECOVER];
                PH_WR_LOW:      len = cfg[REG_WRITE_LOW];
                PH_WR_HOLD:     len = cfg[REG_WRITE_HOLD];
                PH_RD_LOW:      len = cfg[REG_READ_LOW];
                PH_RD_WAIT:     len = cfg[REG_READ_SAMPLE];
                PH_RD_TAIL:     len = cfg[REG_READ_TAIL];
                default:        len = REG_W'(1);
            endcase

            // a zero length or a counter wrap ends the phase too
            tick_inc  = tick_next + COUNT_WIDTH'(1);
            phase_end = (CMP_W'(tick_inc) >= CMP_W'(len)) || (tick_inc == '0);

            if (phase_end)
            begin
                tick_next = '0;
                case (phase_next)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        pres_next  = ~line_level;
                        phase_next = PH_RST_RECOVER;
                    end
                    PH_RST_RECOVER:
                    begin
                        phase_next   = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                    PH_WR_LOW:   phase_next = PH_WR_HOLD;
                    PH_WR_HOLD:
                    begin
                        if (last_bit)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_next + BIT_IDX_W'(1);
                            phase_next   = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:   phase_next = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        shift_next[bit_idx_next] = shift_next[bit_idx_next] | line_level;
                        phase_next = PH_RD_TAIL;
                    end
                    PH_RD_TAIL:
                    begin
                        if (last_bit)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_next + BIT_IDX_W'(1);
                            phase_next   = PH_RD_LOW;
                        end
                    end
                    default:     phase_next = PH_IDLE;
                endcase
            end
            else
            begin
                tick_next = tick_inc;
            end

            if (res.done_res)
            begin
                res.presence  = (kind_next == OP_RESET) && pres_next;
                res.read_data = (kind_next == OP_READ) ? shift_next : '0;
            end
        end

        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            kind_reg    <= OP_NONE;
            pres_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            kind_reg    <= kind_next;
            pres_reg    <= pres_next;
        end
    end

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.done_res |=> phase_reg == PH_IDLE)
        else $error("done tick did not return the sequencer to idle");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.rejected |-> phase_reg != PH_IDLE)
        else $error("command rejected while idle");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> tick_reg == '0)
        else $error("tick counter not cleared in idle");

    a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (phase_reg != PH_IDLE) == $past(res.busy_res))
        else $error("busy flag disagrees with stored phase");

endmodule

@@ hdl/onewire_bus_master.sv @@
// onewire_bus_master: top level of the 1-Wire bus master; stream in, stream
// out, APB timing registers. Depends on owb_pkg, owb_regs, owb_seq.
//
// Channel   Dir  Beat contents
// s_axis    in   one timebase tick: tuser = op, tdata = data_byte, line_level
// m_axis    out  one result per tick: drive_low, busy, done, presence, data, rejected
// apb       in   eight 10-bit timing registers at byte addresses 0x00..0x1C
//
// Cycles: one beat per clock while the output is not stalled; a tick is worked
// out in the cycle it is accepted and its result sits in the output register
// on the next cycle. The phase/counter update is a compare against the selected
// timing register plus a counter wrap check. Reset (rst_n, asynchronous) puts
// the sequencer in idle and loads the default timings. A stalled output register
// holds its beat; the input is taken whenever that register is empty or being drained.
module onewire_bus_master #(
    parameter int COUNT_WIDTH = owb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input tick stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] data_byte, [8] line_level, [15:9] zero
    input  logic [owb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [owb_pkg::OP_W-1:0]        s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
    // [11:4] read_data, [12] rejected, [15:13] zero
    output logic [owb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owb_pkg::APB_AW-1:0]      paddr,
    input  logic [owb_pkg::APB_DW-1:0]      pwdata,
    output logic [owb_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import owb_pkg::*;

    cfg_regs_t              cfg;
    result_t                res;
    logic                   accept;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    // output register empty, or being emptied this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    owb_regs #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owb_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (s_axis_tuser),
        .data_byte  (s_axis_tdata[BITS_PER_BYTE-1:0]),
        .line_level (s_axis_tdata[BITS_PER_BYTE]),
        .cfg        (cfg),
        .res        (res)
    );

    // pack the result, lowest field first
    assign out_data_next = OUT_TDATA_W'({res.rejected, res.read_data, res.presence,
                                         res.done_res, res.busy_res, res.drive_low});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for onewire_bus_master, tick stream in, result stream out.
// Depends on owb_pkg and the onewire_bus_master RTL; a small scoreboard predicts every beat.
module testbench;
    import owb_pkg::*;

    // Sequencer phases as the scoreboard tracks them
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_RST_RECOVER,
        SEQ_WR_LOW,
        SEQ_WR_HOLD,
        SEQ_RD_LOW,
        SEQ_RD_WAIT,
        SEQ_RD_TAIL
    } seq_phase_t;

    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int          DRAIN_TICKS = 4;
    localparam int          PRINT_CAP   = 50;

    // Tracks the bus master tick by tick and holds the result beats still owed.
    class onewire_scoreboard;
        seq_phase_t                   seq_phase;
        logic [COUNT_WIDTH_DEF-1:0]   count;
        logic [BIT_IDX_W-1:0]         bit_pos;
        logic [BITS_PER_BYTE-1:0]     shreg;
        logic [OP_W-1:0]              cmd;
        logic                         answered;
        logic [REG_W-1:0]             timing [NUM_REGS];
        result_t                      due_results [$];
        int unsigned                  failures;
        int unsigned                  commands_done;

        function new();
            seq_phase     = SEQ_IDLE;
            count         = '0;
            bit_pos       = '0;
            shreg         = '0;
            cmd           = OP_NONE;
            answered      = 1'b0;
            failures      = 0;
            commands_done = 0;
            timing[REG_RESET_LOW]     = RST_RESET_LOW;
            timing[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
            timing[REG_RESET_RECOVER] = RST_RESET_RECOVER;
            timing[REG_WRITE_LOW]     = RST_WRITE_LOW;
            timing[REG_WRITE_HOLD]    = RST_WRITE_HOLD;
            timing[REG_READ_LOW]      = RST_READ_LOW;
            timing[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
            timing[REG_READ_TAIL]     = RST_READ_TAIL;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // One accepted tick: advance the sequencer and queue the beat it owes.
        function void note_tick(logic [OP_W-1:0] op, logic [BITS_PER_BYTE-1:0] data,
                                logic level);
            result_t          r;
            logic             now_bit;
            logic             last_slot;
            logic             ended;
            logic [REG_W-1:0] span;
            r     = '0;
            ended = 1'b0;
            if (seq_phase == SEQ_IDLE) begin
                if (op != OP_NONE) begin
                    cmd     = op;
                    count   = '0;
                    bit_pos = '0;
                    shreg   = (op == OP_WRITE) ? data : '0;
                    case (op)
                        OP_RESET: seq_phase = SEQ_RST_LOW;
                        OP_WRITE: seq_phase = SEQ_WR_LOW;
                        default:  seq_phase = SEQ_RD_LOW;
                    endcase
                end
            end
            else if (op != OP_NONE)
                r.rejected = 1'b1;

            if (seq_phase != SEQ_IDLE) begin
                now_bit   = shreg[bit_pos];
                last_slot = (bit_pos == BITS_PER_BYTE - 1);
                case (seq_phase)
                    SEQ_RST_LOW, SEQ_WR_LOW, SEQ_RD_LOW: r.drive_low = 1'b1;
                    SEQ_WR_HOLD:                         r.drive_low = ~now_bit;
                    default:                             r.drive_low = 1'b0;
                endcase
                case (seq_phase)
                    SEQ_RST_LOW:     span = timing[REG_RESET_LOW];
                    SEQ_RST_WAIT:    span = timing[REG_PRESENCE_WAIT];
                    SEQ_RST_RECOVER: span = timing[REG_RESET_RECOVER];
                    SEQ_WR_LOW:      span = timing[REG_WRITE_LOW];
                    SEQ_WR_HOLD:     span = timing[REG_WRITE_HOLD];
                    SEQ_RD_LOW:      span = timing[REG_READ_LOW];
                    SEQ_RD_WAIT:     span = timing[REG_READ_SAMPLE];
                    SEQ_RD_TAIL:     span = timing[REG_READ_TAIL];
                    default:         span = REG_W'(1);
                endcase
                count = count + 1'b1;
                // a zero timing register ends the phase at once and so lasts one tick
                if (count >= span || count == '0) begin
                    count = '0;
                    case (seq_phase)
                        SEQ_RST_LOW: seq_phase = SEQ_RST_WAIT;
                        SEQ_RST_WAIT:
                        begin
                            answered  = ~level;
                            seq_phase = SEQ_RST_RECOVER;
                        end
                        SEQ_RST_RECOVER:
                        begin
                            seq_phase = SEQ_IDLE;
                            ended     = 1'b1;
                        end
                        SEQ_WR_LOW: seq_phase = SEQ_WR_HOLD;
                        SEQ_RD_LOW: seq_phase = SEQ_RD_WAIT;
                        SEQ_RD_WAIT:
                        begin
                            shreg[bit_pos] = shreg[bit_pos] | level;
                            seq_phase      = SEQ_RD_TAIL;
                        end
                        SEQ_WR_HOLD, SEQ_RD_TAIL:
                        begin
                            if (last_slot) begin
                                seq_phase = SEQ_IDLE;
                                ended     = 1'b1;
                            end
                            else begin
                                bit_pos   = bit_pos + 1'b1;
                                seq_phase = (seq_phase == SEQ_WR_HOLD) ? SEQ_WR_LOW : SEQ_RD_LOW;
                            end
                        end
                        default: seq_phase = SEQ_IDLE;
                    endcase
                end
                if (ended) begin
                    r.done_res = 1'b1;
                    commands_done++;
                    if (cmd == OP_RESET)
                        r.presence = answered;
                    if (cmd == OP_READ)
                        r.read_data = shreg;
                end
            end
            r.busy_res = (seq_phase != SEQ_IDLE);
            due_results.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                if (failures <= PRINT_CAP)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        // One accepted result beat against the oldest owed beat.
        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            result_t want;
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= PRINT_CAP)
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, beat);
                return;
            end
            want = due_results.pop_front();
            compare_field("drive_low", want.drive_low, beat[0]);
            compare_field("busy",      want.busy_res,  beat[1]);
            compare_field("done",      want.done_res,  beat[2]);
            compare_field("presence",  want.presence,  beat[3]);
            compare_field("read_data", want.read_data, beat[11:4]);
            compare_field("rejected",  want.rejected,  beat[12]);
            compare_field("padding",   0,              beat[OUT_TDATA_W-1:13]);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT hook-up. Every input starts at a known level.
    // ------------------------------------------------------------------
    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic [OP_W-1:0]        s_axis_tuser   = OP_NONE;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [APB_AW-1:0]      paddr          = '0;
    logic [APB_DW-1:0]      pwdata         = '0;
    wire [APB_DW-1:0]       prdata;
    wire                    pready;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    onewire_bus_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte, [8] line_level, [15:9] zero
        .s_axis_tuser  (s_axis_tuser),   // [1:0] op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] drive_low, [1] busy, [2] done, [3] presence,
                                         // [11:4] read_data, [12] rejected, [15:13] zero
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    onewire_scoreboard         sb;
    int unsigned               ticks_sent  = 0;
    int unsigned               cycles      = 0;
    bit                        line_noise  = 1'b0;
    logic [REG_W-1:0]          plan [NUM_REGS];

    // Gap lengths: one draw in ten from the long range, the rest from the short one.
    function automatic int unsigned pause_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
    endfunction

    // Emulated slave on the wire: answers presence and read slots from the
    // planned reply; elsewhere the level is don't-care and left random.
    // With line_noise set, a sample now and then is random as well.
    function automatic logic line_for(logic [BITS_PER_BYTE-1:0] reply, logic present);
        if (line_noise && $urandom_range(0, 15) == 0)
            return 1'($urandom_range(0, 1));
        case (sb.seq_phase)
            SEQ_RST_WAIT: return ~present;
            SEQ_RD_WAIT:  return reply[sb.bit_pos];
            default:      return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure with calm stretches, and the
    // checker on every accepted beat.
    // ------------------------------------------------------------------
    int unsigned sink_hold = 0;
    int unsigned sink_calm = 0;

    always @(posedge clk)
    begin
        if (sink_calm != 0) begin
            sink_calm     <= sink_calm - 1;
            m_axis_tready <= 1'b1;
        end
        else if (sink_hold != 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= 1'b1;
            case ($urandom_range(0, 19))
                0:          sink_calm <= $urandom_range(50, 300);
                1, 2, 3, 4: sink_hold <= pause_len();
                default:    ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tick side. Called right after a rising edge; valid stays up across
    // back-to-back beats, so it sees a single assignment per step.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [OP_W-1:0] op, input logic [BITS_PER_BYTE-1:0] data,
                             input logic level, input bit calm);
        int unsigned gap;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pause_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_TDATA_W - BITS_PER_BYTE - 1){1'b0}}, level, data};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_tick(op, data, level);
        ticks_sent++;
    endtask

    // A whole command: start tick, then filler ticks until the sequencer
    // is idle again. noise is the percentage of filler ticks that carry a
    // stray command, which must come back rejected.
    task automatic run_command(input logic [OP_W-1:0] op, input logic [BITS_PER_BYTE-1:0] data,
                               input logic [BITS_PER_BYTE-1:0] reply, input logic present,
                               input int unsigned noise);
        bit              calm;
        logic [OP_W-1:0] stray;
        calm = ($urandom_range(0, 3) == 0);
        send_tick(op, data, line_for(reply, present), calm);
        while (sb.seq_phase != SEQ_IDLE) begin
            stray = OP_NONE;
            if ($urandom_range(0, 99) < noise)
                stray = OP_W'($urandom_range(1, 3));
            send_tick(stray, BITS_PER_BYTE'($urandom), line_for(reply, present), calm);
        end
    endtask

    // Hold the sender off until every owed beat has come back, plus a margin.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);
    endtask

    // APB write: setup then access; the register takes the value on the
    // edge where the access phase completes. Upper data bits are junk.
    // The bus is left selected so writes can follow back to back.
    task automatic write_timing(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] ticks);
        logic [APB_DW-1:0] word;
        word             = $urandom;
        word[REG_W-1:0]  = ticks;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.timing[idx] = ticks;
    endtask

    // APB read: setup then access; prdata is taken on the completing edge.
    task automatic read_timing(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.compare_field("timing register", want, prdata);
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_plan();
        settle();
        for (int i = 0; i < NUM_REGS; i++)
            write_timing(REG_IDX_W'(i), plan[i]);
        apb_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned     start_ticks;
        int unsigned     start_done;
        logic [OP_W-1:0] op_pick;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-up timings read back over APB
        for (int i = 0; i < NUM_REGS; i++)
            read_timing(REG_IDX_W'(i), sb.timing[i]);
        apb_idle();

        // short fixed timings for the directed part
        plan = '{10'd2, 10'd3, 10'd2, 10'd2, 10'd3, 10'd1, 10'd2, 10'd2};
        apply_plan();
        run_command(OP_RESET, 8'h00, 8'h00, 1'b1, 0);   // presence seen
        run_command(OP_RESET, 8'hFF, 8'h00, 1'b0, 0);   // nobody answers
        run_command(OP_WRITE, 8'h00, 8'h00, 1'b0, 0);
        run_command(OP_WRITE, 8'hA5, 8'h00, 1'b0, 40);  // commands while busy
        run_command(OP_READ,  8'h00, 8'hFF, 1'b0, 0);
        run_command(OP_READ,  8'h3C, 8'h5A, 1'b1, 40);
        // no command on an idle bus: all quiet whatever the level
        send_tick(OP_NONE, 8'hFF, 1'b1, 1'b0);
        send_tick(OP_NONE, 8'h00, 1'b0, 1'b0);
        send_tick(OP_NONE, 8'h5A, 1'b1, 1'b1);

        // zero in every timing register counts as a single tick
        plan = '{default: 10'd0};
        apply_plan();
        run_command(OP_RESET, 8'h00, 8'h00, 1'b1, 10);
        run_command(OP_WRITE, 8'h3C, 8'h00, 1'b0, 10);
        run_command(OP_READ,  8'h00, 8'hC3, 1'b0, 10);

        // longer slots, several ticks in every phase
        plan = '{10'd16, 10'd8, 10'd16, 10'd2, 10'd3, 10'd2, 10'd2, 10'd3};
        apply_plan();
        run_command(OP_RESET, 8'h00, 8'h00, 1'b1, 1);
        run_command(OP_WRITE, 8'h96, 8'h00, 1'b0, 1);
        run_command(OP_READ,  8'h00, 8'h69, 1'b0, 1);

        // random part: random timings per phase, mostly short slots,
        // well-formed commands with stray commands and noisy samples mixed in
        line_noise  = 1'b1;
        start_ticks = ticks_sent;
        start_done  = sb.commands_done;
        while (ticks_sent - start_ticks < 120 || sb.commands_done - start_done < 6) begin
            foreach (plan[i])
                case ($urandom_range(0, 19))
                    0:       plan[i] = '0;
                    1:       plan[i] = REG_W'($urandom_range(5, 12));
                    default: plan[i] = REG_W'($urandom_range(1, 4));
                endcase
            apply_plan();
            repeat ($urandom_range(2, 4)) begin
                repeat ($urandom_range(0, 2))
                    send_tick(OP_NONE, BITS_PER_BYTE'($urandom), 1'($urandom_range(0, 1)), 1'b0);
                op_pick = OP_W'($urandom_range(1, 3));
                run_command(op_pick, BITS_PER_BYTE'($urandom), BITS_PER_BYTE'($urandom),
                            1'($urandom_range(0, 1)), 6);
            end
        end

        settle();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
